// ----- sv/vohist_pkg.sv -----
// Package for the value occurrence histogram: sizes, defaults and the
// command and result records passed between the front, the queues and the back.
// Depends on nothing.
package vohist_pkg;

  localparam int BINS_DEF       = 64;
  localparam int COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam int SAMPLE_W  = 16;
  localparam int IDX_OUT_W = 6;
  localparam int CNT_OUT_W = 16;

  // One unit of work for the back end: an optional bin increment, then an
  // optional readout from bin zero up to top.
  typedef struct packed {
    logic                 inc;
    logic [IDX_OUT_W-1:0] bin;
    logic                 rdout;
    logic [IDX_OUT_W-1:0] top;
  } cmd_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] idx;
    logic [CNT_OUT_W-1:0] cnt;
    logic                 last;
  } res_t;

endpackage

// ----- sv/vohist_fifo.sv -----
// Small first-in first-out queue of records of any packed type.
// Depends on nothing; used for both the command and the result queue.
module vohist_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- sv/vohist_front.sv -----
// Front end: accepts samples, decides whether each one is counted, tracks the
// largest sample of the set and turns the final sample into a readout command.
// Depends on vohist_pkg.
module vohist_front #(
  parameter int BINS = vohist_pkg::BINS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [vohist_pkg::SAMPLE_W-1:0] sample,
  input  logic                                  final_item,
  output logic                                  cq_push,
  output vohist_pkg::cmd_t                      cq_cmd,
  input  logic                                  cq_full
);
  import vohist_pkg::*;

  logic                       accept;
  logic                       in_range;
  logic                       any_seen_r, any_seen_nxt;
  logic signed [SAMPLE_W-1:0] largest_r, largest_nxt;
  logic signed [SAMPLE_W-1:0] largest_upd;

  assign full   = cq_full;
  assign accept = push && !cq_full;

  // Only samples in 0..BINS-1 land in a bin.
  assign in_range = !sample[SAMPLE_W-1] &&
                    (sample[SAMPLE_W-2:0] < (SAMPLE_W-1)'(BINS));

  // Largest value including the current sample.
  assign largest_upd = (!any_seen_r || (sample > largest_r)) ? sample : largest_r;

  always_comb begin
    cq_cmd.inc   = in_range;
    cq_cmd.bin   = sample[IDX_OUT_W-1:0];
    cq_cmd.rdout = final_item && !largest_upd[SAMPLE_W-1];
    if (largest_upd[SAMPLE_W-2:0] > (SAMPLE_W-1)'(BINS - 1)) begin
      cq_cmd.top = IDX_OUT_W'(BINS - 1);
    end else begin
      cq_cmd.top = largest_upd[IDX_OUT_W-1:0];
    end
  end

  // A sample that neither counts nor starts readout needs no command.
  assign cq_push = accept && (cq_cmd.inc || cq_cmd.rdout);

  always_comb begin
    any_seen_nxt = any_seen_r;
    largest_nxt  = largest_r;
    if (accept) begin
      if (final_item) begin
        any_seen_nxt = 1'b0;
        largest_nxt  = '0;
      end else begin
        any_seen_nxt = 1'b1;
        largest_nxt  = largest_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_seen_r <= 1'b0;
      largest_r  <= '0;
    end else begin
      any_seen_r <= any_seen_nxt;
      largest_r  <= largest_nxt;
    end
  end

endmodule

// ----- sv/vohist_back.sv -----
// Back end: holds the bin counts in a memory with per-bin valid bits, performs
// saturating increments and walks the bins on readout, clearing them as it goes.
// Depends on vohist_pkg.
module vohist_back #(
  parameter int BINS       = vohist_pkg::BINS_DEF,
  parameter int COUNT_BITS = vohist_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cq_empty,
  input  vohist_pkg::cmd_t cq_cmd,
  output logic             cq_pop,
  input  logic             rq_full,
  output logic             rq_push,
  output vohist_pkg::res_t rq_res
);
  import vohist_pkg::*;

  localparam int IDX_W = $clog2(BINS);

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_INC_RD = 5'b00010,
    B_INC_WR = 5'b00100,
    B_OUT_RD = 5'b01000,
    B_OUT_WR = 5'b10000
  } bstate_t;

  bstate_t               state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [IDX_W-1:0]      v_r, v_nxt;

  logic [COUNT_BITS-1:0] cnt_mem [BINS];
  logic [BINS-1:0]       bin_vld_r, bin_vld_nxt;
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  rd_vld_r;

  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] cur;
  logic [CNT_OUT_W-1:0]  cnt_clip;
  logic                  at_top;

  // A bin that has not been written since reset or readout reads as zero.
  assign cur    = rd_vld_r ? rd_data_r : '0;
  assign at_top = (v_r == cmd_r.top[IDX_W-1:0]);

  generate
    if (COUNT_BITS > CNT_OUT_W) begin : g_clip
      assign cnt_clip = (|cur[COUNT_BITS-1:CNT_OUT_W]) ? '1 : cur[CNT_OUT_W-1:0];
    end else begin : g_ext
      assign cnt_clip = CNT_OUT_W'(cur);
    end
  endgenerate

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    v_nxt       = v_r;
    bin_vld_nxt = bin_vld_r;
    cq_pop      = 1'b0;
    rq_push     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cmd_r.bin[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = cmd_r.bin[IDX_W-1:0];
    wr_data     = (cur == '1) ? cur : cur + 1'b1;
    rq_res.idx  = IDX_OUT_W'(v_r);
    rq_res.cnt  = cnt_clip;
    rq_res.last = at_top;
    case (state_r)
      B_IDLE: begin
        if (!cq_empty) begin
          cq_pop  = 1'b1;
          cmd_nxt = cq_cmd;
          v_nxt   = '0;
          if (cq_cmd.inc) begin
            state_nxt = B_INC_RD;
          end else if (cq_cmd.rdout) begin
            state_nxt = B_OUT_RD;
          end
        end
      end
      B_INC_RD: begin
        rd_en     = 1'b1;
        state_nxt = B_INC_WR;
      end
      B_INC_WR: begin
        wr_en                              = 1'b1;
        bin_vld_nxt[cmd_r.bin[IDX_W-1:0]] = 1'b1;
        state_nxt = cmd_r.rdout ? B_OUT_RD : B_IDLE;
      end
      B_OUT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = v_r;
        state_nxt = B_OUT_WR;
      end
      B_OUT_WR: begin
        if (!rq_full) begin
          rq_push          = 1'b1;
          bin_vld_nxt[v_r] = 1'b0;
          if (at_top) begin
            state_nxt = B_IDLE;
          end else begin
            v_nxt     = v_r + 1'b1;
            state_nxt = B_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      bin_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bin_vld_r <= bin_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    v_r   <= v_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= cnt_mem[rd_addr];
      rd_vld_r  <= bin_vld_r[rd_addr];
    end
  end

endmodule

// ----- sv/value_occurrence_histogram.sv -----
// Value occurrence histogram: the counting phase of a counting sort.
// Top level joining the front end, the command queue, the back end and the
// result queue. Depends on vohist_pkg, vohist_fifo, vohist_front, vohist_back.
//
// Samples are pushed one per request; each one in 0..BINS-1 adds one to its
// bin, saturating at the top of the count width, and the largest sample of the
// set is tracked. The request that carries final_item starts a readout: one
// result per value from zero up to the smaller of the largest sample and
// BINS-1, in ascending order, with final_bin set on the last. If every sample
// of the set was negative, the set produces no results. The bins and the
// largest value are then clear for the next set. The front end takes a sample
// every cycle while the four-entry command queue has room; the back end handles
// each counted sample in order by taking the command from the queue, a
// registered memory read, then the write of the incremented count, and each
// readout result by a registered memory read, then its push into the result
// queue. Samples outside the bin range cost the back end nothing unless they
// end the set. Results wait in a four-entry queue, and the back end stalls
// only while that queue is full. After reset all bins read as zero at once:
// each bin has a valid bit that reset clears, so there is no clearing pass.
module value_occurrence_histogram #(
  parameter int BINS       = vohist_pkg::BINS_DEF,
  parameter int COUNT_BITS = vohist_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [vohist_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                   in_final_item,
  output logic                                   empty,
  input  logic                                   pop,
  output logic        [vohist_pkg::IDX_OUT_W-1:0] out_bin_index,
  output logic        [vohist_pkg::CNT_OUT_W-1:0] out_bin_count,
  output logic                                   out_final_bin
);
  import vohist_pkg::*;

  // Command queue between the front and the back end.
  logic cq_push, cq_full, cq_pop, cq_empty;
  cmd_t cq_wr_cmd, cq_rd_cmd;

  // Result queue between the back end and the output ports.
  logic rq_push, rq_full;
  res_t rq_wr_res, rq_head;

  vohist_front #(
    .BINS(BINS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .sample    (in_sample),
    .final_item(in_final_item),
    .cq_push   (cq_push),
    .cq_cmd    (cq_wr_cmd),
    .cq_full   (cq_full)
  );

  vohist_fifo #(
    .T    (cmd_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cq_push),
    .din  (cq_wr_cmd),
    .full (cq_full),
    .pop  (cq_pop),
    .dout (cq_rd_cmd),
    .empty(cq_empty)
  );

  vohist_back #(
    .BINS      (BINS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cq_empty(cq_empty),
    .cq_cmd  (cq_rd_cmd),
    .cq_pop  (cq_pop),
    .rq_full (rq_full),
    .rq_push (rq_push),
    .rq_res  (rq_wr_res)
  );

  vohist_fifo #(
    .T    (res_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (rq_push),
    .din  (rq_wr_res),
    .full (rq_full),
    .pop  (pop),
    .dout (rq_head),
    .empty(empty)
  );

  // The oldest waiting result drives the output fields.
  assign out_bin_index = rq_head.idx;
  assign out_bin_count = rq_head.cnt;
  assign out_final_bin = rq_head.last;

endmodule

// ----- sv/vohist_chk.sv -----
// Port-level checker for the value occurrence histogram, with its bind.
// Depends on vohist_pkg and on the ports of value_occurrence_histogram.
module vohist_chk #(
  parameter int BINS = vohist_pkg::BINS_DEF
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   empty,
  input logic                                   pop,
  input logic        [vohist_pkg::IDX_OUT_W-1:0] out_bin_index,
  input logic        [vohist_pkg::CNT_OUT_W-1:0] out_bin_count,
  input logic                                   out_final_bin
);
  import vohist_pkg::*;

  // Index that the next delivered result must carry: each readout run counts
  // up from zero, and a new run begins after a result with final_bin.
  logic [IDX_OUT_W-1:0] exp_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (pop && !empty) begin
      exp_idx_r <= out_final_bin ? '0 : out_bin_index + 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_bin_index) &&
                          $stable(out_bin_count) && $stable(out_final_bin)))
    else $error("waiting result changed or vanished while stalled");

  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty) |-> (out_bin_index == exp_idx_r))
    else $error("readout index out of sequence");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_bin_index <= IDX_OUT_W'(BINS - 1)))
    else $error("reported bin beyond the last bin");

endmodule

bind value_occurrence_histogram vohist_chk #(
  .BINS(BINS)
) u_vohist_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .empty        (empty),
  .pop          (pop),
  .out_bin_index(out_bin_index),
  .out_bin_count(out_bin_count),
  .out_final_bin(out_final_bin)
);
